FILE: design/ptt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptt_pkg
// Shared types and constants of the periodic timer table.
// ----------------------------------------------------------------------------
package ptt_pkg;

  localparam int NUM_TIMERS_DEF = 16;
  localparam int MAX_RESULTS    = 16;
  localparam int ACT_W          = 5;
  localparam int RES_W          = $clog2(MAX_RESULTS + 1);

  typedef enum logic [1:0] {
    OP_SET   = 2'd0,
    OP_KILL  = 2'd1,
    OP_TICK  = 2'd2,
    OP_CLEAR = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    KIND_STATUS    = 2'd0,
    KIND_EXPIRED   = 2'd1,
    KIND_IDLE_TICK = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    STS_OK          = 2'd0,
    STS_BAD_ID      = 2'd1,
    STS_ZERO_PERIOD = 2'd2,
    STS_NOT_ACTIVE  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMD,
    S_SCAN,
    S_FIN
  } state_t;

endpackage

FILE: design/ptt_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptt_in_if / ptt_out_if
// Valid/ready channels of the periodic timer table.
// ----------------------------------------------------------------------------
interface ptt_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [7:0]  timer_id;
  logic [31:0] period;
  logic [31:0] now_time;

  modport source (output valid, output op, output timer_id, output period,
                  output now_time, input ready);
  modport sink   (input valid, input op, input timer_id, input period,
                  input now_time, output ready);
endinterface

interface ptt_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [1:0] status;
  logic [3:0] expired_id;
  logic       last;

  modport source (output valid, output kind, output status, output expired_id,
                  output last, input ready);
  modport sink   (input valid, input kind, input status, input expired_id,
                  input last, output ready);
endinterface

FILE: design/periodic_timer_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// periodic_timer_table
// Table of periodic timers with set, kill, tick and clear commands.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one command beat (op, timer_id, period, now_time); out_ch
//   carries result beats (kind, status, expired_id, last), last marking the
//   final beat of a command. in_ch.ready is high only while the sequencer
//   is idle, so commands are taken one at a time.
//   Set, kill and clear are accepted, then update the table and load the
//   output register. A tick with active timers does one registered read of
//   the period and deadline memories per slot, overlapped with the compare
//   and the shared 32-bit reload adder of the previous slot, then sends the
//   final beat. A tick with no active timer goes straight to the final beat.
//   Each expiry beat is held until the next is found so the final one can carry last.
//   When out_ch stalls, the scan stops at the next emitting slot until the
//   output register drains; the next command is accepted while the last
//   beat still waits.
//   Reset clears the armed bits and the active count at once; the memories
//   need no clearing since a slot's contents are used only while it is armed.
// ----------------------------------------------------------------------------
module periodic_timer_table
  import ptt_pkg::*;
#(
  parameter int NUM_TIMERS = NUM_TIMERS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  ptt_in_if.sink         in_ch,
  ptt_out_if.source      out_ch
);

  localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

  state_t                  state_r, state_nxt;
  op_t                     op_r, op_nxt;
  logic [7:0]              id_r, id_nxt;
  logic [31:0]             period_r, period_nxt;
  logic [31:0]             now_r, now_nxt;
  logic [IDX_W-1:0]        idx_r, idx_nxt;
  logic [NUM_TIMERS-1:0]   armed_r, armed_nxt;
  logic [ACT_W-1:0]        active_r, active_nxt;
  logic [RES_W-1:0]        cnt_r, cnt_nxt;
  logic                    held_v_r, held_v_nxt;
  logic [IDX_W-1:0]        held_id_r, held_id_nxt;
  logic                    out_valid_r, out_valid_nxt;
  kind_t                   out_kind_r, out_kind_nxt;
  status_t                 out_status_r, out_status_nxt;
  logic [3:0]              out_id_r, out_id_nxt;
  logic                    out_last_r, out_last_nxt;

  logic [31:0]             period_mem [NUM_TIMERS];
  logic [31:0]             dead_mem   [NUM_TIMERS];
  logic [31:0]             rd_period_r;
  logic [31:0]             rd_dead_r;

  logic                    in_fire;
  logic                    slot_free;
  logic                    id_ok;
  logic [IDX_W-1:0]        id_idx;
  logic                    idx_last;
  logic [31:0]             add_b;
  logic [31:0]             sum;
  logic                    hit;
  logic                    emit_hit;
  logic                    scan_stall;
  logic                    advance;
  status_t                 cmd_status;

  logic                    push;
  kind_t                   push_kind;
  status_t                 push_status;
  logic [3:0]              push_id;
  logic                    push_last;
  logic                    we_period;
  logic                    we_dead;
  logic [IDX_W-1:0]        wr_addr;
  logic [IDX_W-1:0]        rd_addr;

  assign in_ch.ready       = (state_r == S_IDLE);
  assign in_fire           = in_ch.valid && in_ch.ready;
  assign out_ch.valid      = out_valid_r;
  assign out_ch.kind       = out_kind_r;
  assign out_ch.status     = out_status_r;
  assign out_ch.expired_id = out_id_r;
  assign out_ch.last       = out_last_r;

  assign slot_free = !out_valid_r || out_ch.ready;
  assign id_ok     = id_r < 8'(NUM_TIMERS);
  assign id_idx    = id_r[IDX_W-1:0];
  assign idx_last  = (idx_r == IDX_W'(NUM_TIMERS - 1));

  // shared reload adder: set uses the new period, scan the stored one
  assign add_b = (state_r == S_SCAN) ? rd_period_r : period_r;
  assign sum   = now_r + add_b;

  assign hit        = armed_r[idx_r] && (rd_dead_r <= now_r);
  assign emit_hit   = hit && (cnt_r < RES_W'(MAX_RESULTS));
  assign scan_stall = emit_hit && held_v_r && !slot_free;
  assign advance    = (state_r == S_SCAN) && !scan_stall;

  always_comb begin
    cmd_status = STS_OK;
    case (op_r)
      OP_SET: begin
        if (!id_ok) cmd_status = STS_BAD_ID;
        else if (period_r == 32'd0) cmd_status = STS_ZERO_PERIOD;
      end
      OP_KILL: begin
        if (!id_ok) cmd_status = STS_BAD_ID;
        else if (!armed_r[id_idx]) cmd_status = STS_NOT_ACTIVE;
      end
      default: cmd_status = STS_OK;
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (op_t'(in_ch.op) == OP_TICK) begin
            state_nxt = (active_r == '0) ? S_FIN : S_SCAN;
          end else begin
            state_nxt = S_CMD;
          end
        end
      end
      S_CMD:   if (slot_free) state_nxt = S_IDLE;
      S_SCAN:  if (advance && idx_last) state_nxt = S_FIN;
      S_FIN:   if (slot_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    push        = 1'b0;
    push_kind   = KIND_STATUS;
    push_status = STS_OK;
    push_id     = 4'd0;
    push_last   = 1'b0;
    we_period   = 1'b0;
    we_dead     = 1'b0;
    wr_addr     = id_idx;
    rd_addr     = '0;
    case (state_r)
      S_IDLE: rd_addr = '0;
      S_CMD: begin
        if (slot_free) begin
          push        = 1'b1;
          push_status = cmd_status;
          push_last   = 1'b1;
          if (op_r == OP_SET && cmd_status == STS_OK) begin
            we_period = 1'b1;
            we_dead   = 1'b1;
          end
        end
      end
      S_SCAN: begin
        wr_addr = idx_r;
        // hold the read address while stalled so the same slot comes back
        rd_addr = (advance && !idx_last) ? idx_r + 1'b1 : idx_r;
        if (advance) begin
          we_dead = hit;
          if (emit_hit && held_v_r) begin
            push      = 1'b1;
            push_kind = KIND_EXPIRED;
            push_id   = 4'(held_id_r);
          end
        end
      end
      S_FIN: begin
        if (slot_free) begin
          push      = 1'b1;
          push_last = 1'b1;
          if (held_v_r) begin
            push_kind = KIND_EXPIRED;
            push_id   = 4'(held_id_r);
          end else begin
            push_kind = KIND_IDLE_TICK;
          end
        end
      end
      default: ;
    endcase
  end

  // register next values
  always_comb begin
    op_nxt         = op_r;
    id_nxt         = id_r;
    period_nxt     = period_r;
    now_nxt        = now_r;
    idx_nxt        = idx_r;
    armed_nxt      = armed_r;
    active_nxt     = active_r;
    cnt_nxt        = cnt_r;
    held_v_nxt     = held_v_r;
    held_id_nxt    = held_id_r;
    out_valid_nxt  = out_valid_r;
    out_kind_nxt   = out_kind_r;
    out_status_nxt = out_status_r;
    out_id_nxt     = out_id_r;
    out_last_nxt   = out_last_r;

    if (in_fire) begin
      op_nxt     = op_t'(in_ch.op);
      id_nxt     = in_ch.timer_id;
      period_nxt = in_ch.period;
      now_nxt    = in_ch.now_time;
      idx_nxt    = '0;
      cnt_nxt    = '0;
      held_v_nxt = 1'b0;
    end

    if (state_r == S_CMD && slot_free && cmd_status == STS_OK) begin
      case (op_r)
        OP_SET: begin
          if (!armed_r[id_idx]) active_nxt = active_r + 1'b1;
          armed_nxt[id_idx] = 1'b1;
        end
        OP_KILL: begin
          armed_nxt[id_idx] = 1'b0;
          active_nxt        = active_r - 1'b1;
        end
        OP_CLEAR: begin
          armed_nxt  = '0;
          active_nxt = '0;
        end
        default: ;
      endcase
    end

    if (advance) begin
      if (!idx_last) idx_nxt = idx_r + 1'b1;
      if (emit_hit) begin
        held_v_nxt  = 1'b1;
        held_id_nxt = idx_r;
        cnt_nxt     = cnt_r + 1'b1;
      end
    end

    if (state_r == S_FIN && slot_free) held_v_nxt = 1'b0;

    if (push) begin
      out_valid_nxt  = 1'b1;
      out_kind_nxt   = push_kind;
      out_status_nxt = push_status;
      out_id_nxt     = push_id;
      out_last_nxt   = push_last;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= '0;
      armed_r     <= '0;
      active_r    <= '0;
      cnt_r       <= '0;
      held_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      armed_r     <= armed_nxt;
      active_r    <= active_nxt;
      cnt_r       <= cnt_nxt;
      held_v_r    <= held_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    id_r         <= id_nxt;
    period_r     <= period_nxt;
    now_r        <= now_nxt;
    held_id_r    <= held_id_nxt;
    out_kind_r   <= out_kind_nxt;
    out_status_r <= out_status_nxt;
    out_id_r     <= out_id_nxt;
    out_last_r   <= out_last_nxt;
  end

  // period and deadline memories, registered read
  always_ff @(posedge clk) begin
    if (we_period) period_mem[wr_addr] <= period_r;
    if (we_dead)   dead_mem[wr_addr]   <= sum;
    rd_period_r <= period_mem[rd_addr];
    rd_dead_r   <= dead_mem[rd_addr];
  end

  // checks
  a_active_matches_armed: assert property (@(posedge clk) disable iff (!rst_n)
    active_r == ACT_W'($countones(armed_r)))
    else $error("active count differs from armed slots");

  a_push_into_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> slot_free)
    else $error("result beat overwrites a waiting beat");

  a_result_limit: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= RES_W'(MAX_RESULTS))
    else $error("result count beyond limit");

  a_idle_nothing_held: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !held_v_r)
    else $error("expiry beat left behind after tick");

  a_scan_no_write_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN && scan_stall) |=> (state_r == S_SCAN && $stable(idx_r)))
    else $error("scan moved on during output stall");

endmodule

FILE: tb/periodic_timer_table_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// periodic_timer_table_tb
// Self-checking bench for the periodic timer table: directed corner commands,
// then random set/kill/tick/clear traffic under varying sender idle and
// receiver stall rates, each result beat checked against a timer-table model.
// ----------------------------------------------------------------------------
module periodic_timer_table_tb;
  import ptt_pkg::*;

  localparam int NUM_TIMERS  = NUM_TIMERS_DEF;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PRINT_LIMIT = 40;

  typedef struct packed {
    op_t         op;
    logic [7:0]  timer_id;
    logic [31:0] period;
    logic [31:0] now_time;
  } timer_cmd_t;

  typedef struct packed {
    kind_t      kind;
    status_t    status;
    logic [3:0] expired_id;
    logic       last;
  } timer_beat_t;

  logic clk;
  logic rst_n;

  ptt_in_if  in_ch ();
  ptt_out_if out_ch ();

  periodic_timer_table #(
    .NUM_TIMERS(NUM_TIMERS)
  ) DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // timer table model state
  logic [31:0]      period_tbl   [NUM_TIMERS];
  logic [31:0]      deadline_tbl [NUM_TIMERS];
  logic [ACT_W-1:0] armed_cnt;

  timer_cmd_t  cmd_backlog [$];
  timer_beat_t predicted_beats [$];
  timer_cmd_t  cur_cmd;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_len       = 0;
  int hold_seq       = 0;
  int hold_seen      = 0;
  int hold_left      = 0;

  int err_cnt      = 0;
  int cmds_taken   = 0;
  int beats_seen   = 0;
  int expiry_beats = 0;
  int idle_ticks   = 0;
  int max_burst    = 0;
  int burst_len    = 0;
  int cycle_cnt    = 0;

  logic [31:0] clock_now;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    err_cnt++;
    if (err_cnt <= PRINT_LIMIT)
      $display("MISMATCH at %0t: %s", $realtime, msg);
  endtask

  // updates the table model for one command and queues the beats it causes
  task automatic apply_timer_cmd(input timer_cmd_t c);
    timer_beat_t beat;
    timer_beat_t held;
    bit          have_held;
    int          n;
    int          slot;
    beat      = '{KIND_STATUS, STS_OK, 4'd0, 1'b1};
    have_held = 1'b0;
    held      = beat;
    n         = 0;
    slot      = int'(c.timer_id);
    case (c.op)
      OP_SET: begin
        if (slot >= NUM_TIMERS) begin
          beat.status = STS_BAD_ID;
        end else if (c.period == 32'd0) begin
          beat.status = STS_ZERO_PERIOD;
        end else begin
          if (period_tbl[slot] == 32'd0) armed_cnt = armed_cnt + 1'b1;
          period_tbl[slot]   = c.period;
          deadline_tbl[slot] = c.now_time + c.period;
        end
        predicted_beats.push_back(beat);
      end
      OP_KILL: begin
        if (slot >= NUM_TIMERS) begin
          beat.status = STS_BAD_ID;
        end else if (period_tbl[slot] == 32'd0) begin
          beat.status = STS_NOT_ACTIVE;
        end else begin
          period_tbl[slot] = 32'd0;
          armed_cnt = armed_cnt - 1'b1;
        end
        predicted_beats.push_back(beat);
      end
      OP_TICK: begin
        if (armed_cnt != '0) begin
          for (int s = 0; s < NUM_TIMERS; s++) begin
            if (period_tbl[s] != 32'd0 && deadline_tbl[s] <= c.now_time) begin
              if (n < MAX_RESULTS) begin
                // one beat held back so the final one can carry last
                if (have_held) predicted_beats.push_back(held);
                held = '{KIND_EXPIRED, STS_OK, 4'(s), 1'b0};
                have_held = 1'b1;
                n++;
              end
              deadline_tbl[s] = c.now_time + period_tbl[s];
            end
          end
        end
        if (have_held) begin
          held.last = 1'b1;
          predicted_beats.push_back(held);
        end else begin
          beat.kind = KIND_IDLE_TICK;
          predicted_beats.push_back(beat);
        end
      end
      default: begin
        for (int s = 0; s < NUM_TIMERS; s++) period_tbl[s] = 32'd0;
        armed_cnt = '0;
        predicted_beats.push_back(beat);
      end
    endcase
  endtask

  // command driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        apply_timer_cmd(cur_cmd);
        cmds_taken++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (cmd_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          cur_cmd = cmd_backlog.pop_front();
          in_ch.valid    <= 1'b1;
          in_ch.op       <= cur_cmd.op;
          in_ch.timer_id <= cur_cmd.timer_id;
          in_ch.period   <= cur_cmd.period;
          in_ch.now_time <= cur_cmd.now_time;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off, counted here
  always @(posedge clk) begin
    if (hold_seq != hold_seen) begin
      hold_seen <= hold_seq;
      hold_left <= hold_len;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    out_ch.ready <= rst_n && (hold_left == 0) && ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // result monitor
  always @(posedge clk) begin
    timer_beat_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      beats_seen++;
      if (out_ch.kind == KIND_EXPIRED) expiry_beats++;
      if (out_ch.kind == KIND_IDLE_TICK) idle_ticks++;
      burst_len = out_ch.last ? 0 : burst_len + 1;
      if (burst_len + 1 > max_burst) max_burst = burst_len + 1;
      if (predicted_beats.size() == 0) begin
        report_mismatch($sformatf("unexpected beat kind=%0d status=%0d id=%0d last=%0b",
                                  out_ch.kind, out_ch.status, out_ch.expired_id,
                                  out_ch.last));
      end else begin
        want = predicted_beats.pop_front();
        if (out_ch.kind !== want.kind)
          report_mismatch($sformatf("kind %0d, want %0d", out_ch.kind, want.kind));
        if (out_ch.status !== want.status)
          report_mismatch($sformatf("status %0d, want %0d", out_ch.status, want.status));
        if (out_ch.expired_id !== want.expired_id)
          report_mismatch($sformatf("expired_id %0d, want %0d", out_ch.expired_id,
                                    want.expired_id));
        if (out_ch.last !== want.last)
          report_mismatch($sformatf("last %0b, want %0b", out_ch.last, want.last));
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d beats still expected", cycle_cnt,
               predicted_beats.size());
      $display("tb: failure");
      $finish;
    end
  end

  task automatic push_cmd(input op_t op, input logic [7:0] id, input logic [31:0] period,
                          input logic [31:0] now_t);
    cmd_backlog.push_back('{op, id, period, now_t});
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (cmd_backlog.size() != 0 || in_ch.valid || predicted_beats.size() != 0);
  endtask

  task automatic set_pace(input int idle_pct, input int stall_pct);
    @(negedge clk);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
  endtask

  // mostly well-formed traffic on an advancing clock, some noise mixed in
  task automatic gen_traffic(input int n_cmds);
    int          made;
    int          sel;
    logic [31:0] per;
    made = 0;
    while (made < n_cmds) begin
      sel = $urandom_range(0, 99);
      if (sel < 35) begin
        clock_now = clock_now + $urandom_range(0, 6);
        push_cmd(OP_TICK, 8'd0, $urandom, clock_now);
        made++;
      end else if (sel < 60) begin
        case ($urandom_range(0, 9))
          0:       per = $urandom;
          1:       per = 32'hFFFF_FFFF - $urandom_range(0, 15);
          default: per = $urandom_range(1, 12);
        endcase
        if (per == 32'd0) per = 32'd1;
        push_cmd(OP_SET, 8'($urandom_range(0, NUM_TIMERS - 1)), per, clock_now);
        made++;
      end else if (sel < 72) begin
        push_cmd(OP_KILL, 8'($urandom_range(0, NUM_TIMERS - 1)), $urandom, $urandom);
        made++;
      end else if (sel < 80) begin
        per = ($urandom_range(0, 3) == 0) ? 32'd0 : $urandom;
        push_cmd(($urandom_range(0, 1) == 0) ? OP_SET : OP_KILL,
                 8'($urandom_range(0, 255)), per, $urandom);
        made++;
      end else if (sel < 84) begin
        push_cmd(OP_CLEAR, 8'($urandom), $urandom, $urandom);
        made++;
      end else if (sel < 88) begin
        // arm every slot, then one tick that expires them all
        for (int s = 0; s < NUM_TIMERS; s++)
          push_cmd(OP_SET, 8'(s), $urandom_range(1, 3), clock_now);
        clock_now = clock_now + 3;
        push_cmd(OP_TICK, 8'd0, 32'd0, clock_now);
        made += NUM_TIMERS + 1;
      end else if (sel < 92) begin
        clock_now = ($urandom_range(0, 1) == 0) ? $urandom
                                                : 32'hFFFF_FFFF - $urandom_range(0, 20);
        push_cmd(OP_TICK, 8'($urandom), $urandom, clock_now);
        made++;
      end else begin
        push_cmd(op_t'($urandom_range(0, 3)), 8'($urandom), $urandom, $urandom);
        made++;
      end
    end
  endtask

  initial begin
    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.op       = OP_SET;
    in_ch.timer_id = 8'd0;
    in_ch.period   = 32'd0;
    in_ch.now_time = 32'd0;
    out_ch.ready   = 1'b0;
    armed_cnt      = '0;
    clock_now      = 32'd0;
    for (int s = 0; s < NUM_TIMERS; s++) begin
      period_tbl[s]   = 32'd0;
      deadline_tbl[s] = 32'd0;
    end
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed corners, no idling
    @(negedge clk);
    push_cmd(OP_TICK,  8'd0,   32'd0,          32'd0);
    push_cmd(OP_KILL,  8'd3,   32'd0,          32'd0);
    push_cmd(OP_SET,   8'd16,  32'd5,          32'd0);
    push_cmd(OP_SET,   8'd255, 32'd0,          32'd0);
    push_cmd(OP_SET,   8'd2,   32'd0,          32'd0);
    push_cmd(OP_KILL,  8'd200, 32'd0,          32'd0);
    push_cmd(OP_SET,   8'd0,   32'd1,          32'd0);
    push_cmd(OP_SET,   8'd15,  32'hFFFF_FFFF,  32'hFFFF_FFFF);
    push_cmd(OP_SET,   8'd7,   32'd10,         32'd0);
    push_cmd(OP_SET,   8'd7,   32'd4,          32'd0);
    push_cmd(OP_TICK,  8'd0,   32'd0,          32'd0);
    push_cmd(OP_TICK,  8'd0,   32'd0,          32'd1);
    push_cmd(OP_TICK,  8'd0,   32'd0,          32'd4);
    push_cmd(OP_KILL,  8'd0,   32'd0,          32'd0);
    push_cmd(OP_KILL,  8'd0,   32'd0,          32'd0);
    push_cmd(OP_TICK,  8'd0,   32'd0,          32'hFFFF_FFFF);
    push_cmd(OP_CLEAR, 8'd0,   32'd0,          32'd0);
    push_cmd(OP_TICK,  8'd0,   32'd0,          32'hFFFF_FFFF);
    push_cmd(OP_KILL,  8'd15,  32'd0,          32'd0);
    push_cmd(OP_SET,   8'd9,   32'h8000_0000,  32'h8000_0000);
    push_cmd(OP_TICK,  8'd0,   32'd0,          32'd0);
    push_cmd(OP_CLEAR, 8'd0,   32'd0,          32'd0);
    wait_drained();

    gen_traffic(45);
    wait_drained();

    // receiver holds off while commands keep coming, so the block backs up
    @(negedge clk);
    hold_len = 400;
    hold_seq = hold_seq + 1;
    gen_traffic(25);
    wait_drained();

    set_pace(61, 0);
    gen_traffic(40);
    wait_drained();

    set_pace(0, 61);
    gen_traffic(40);
    wait_drained();

    set_pace(17, 17);
    gen_traffic(40);
    wait_drained();

    repeat (4 * NUM_TIMERS) @(posedge clk);
    if (predicted_beats.size() != 0)
      report_mismatch($sformatf("%0d beats never arrived", predicted_beats.size()));
    $display("%0d commands taken, %0d result beats checked", cmds_taken, beats_seen);
    $display("%0d expiry beats, %0d idle ticks, longest tick burst %0d beats",
             expiry_beats, idle_ticks, max_burst);
    if (err_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
